@@ rtl/tscu_pkg.sv @@
// tscu_pkg: widths, sideband struct and fixed constants of the taylor sine/cosine unit
// shared by tscu_half_step and taylor_sine_cosine_unit_top; depends on nothing
`default_nettype none
package tscu_pkg;

  // series term magnitude and accumulator widths
  localparam int unsigned TW   = 44;
  localparam int unsigned HW   = 22;
  localparam int unsigned SW   = 48;
  localparam int unsigned AXW  = 32;
  localparam int unsigned FRAC = 28;

  // constant division: numerator width, remainder width, divisor width
  localparam int unsigned DIV_N = 29;
  localparam int unsigned RW    = 7;
  localparam int unsigned DW    = 8;

  // mode bits
  localparam int unsigned MODE_COS_BIT = 0;
  localparam int unsigned MODE_DEG_BIT = 1;

  // degree to radian scaling, 2^28 / 57.29577951 as a ratio of integers
  localparam logic [63:0] DEG_NUM  = 64'd26843545600000000;
  localparam logic [63:0] DEG_DEN  = 64'd5729577951;
  localparam logic [63:0] DEG_TURN = 64'd360;
  localparam logic [22:0] DEG_Q    = 23'(DEG_NUM / DEG_DEN);
  localparam logic [32:0] DEG_R    = 33'(DEG_NUM % DEG_DEN);
  localparam logic [31:0] DEG_H    = 32'(DEG_DEN / 64'd2);
  localparam logic [32:0] DEG_D    = 33'(DEG_DEN);
  localparam logic [11:0] DEG_MINV = 12'((64'd1 << 44) / DEG_DEN);
  localparam logic [23:0] MINV360  = 24'((64'd1 << 32) / DEG_TURN);

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [31:0] Q30_MIN_ONE = 32'hC000_0000;
  localparam logic signed [SW-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [SW-1:0] SAT_LO = 48'shFFFF_8000_0000;

  typedef struct packed {
    logic                 cosine;
    logic                 neg;
    logic                 spec;
    logic                 spec_one;
    logic                 spec_neg;
    logic [AXW-1:0]       ax;
    logic signed [SW-1:0] sum;
  } tscu_sb_t;

endpackage
`default_nettype wire

@@ rtl/tscu_half_step.sv @@
// tscu_half_step: one half of a series term, t = floor(floor(t*ax/2^28)/d)
// six register stages; divisor picked by the cosine bit; uses tscu_pkg
`default_nettype none
module tscu_half_step #(
  parameter int unsigned DIV_SIN = 2,
  parameter int unsigned DIV_COS = 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tscu_pkg::TW-1:0]  t_i,
  input  tscu_pkg::tscu_sb_t       sb_i,
  output logic                     valid_o,
  output logic [tscu_pkg::TW-1:0]  t_o,
  output tscu_pkg::tscu_sb_t       sb_o
);
  import tscu_pkg::*;

  localparam int unsigned PPW = HW + AXW;
  localparam int unsigned SUMW = PPW + HW;
  localparam int unsigned PRW = 2 * DIV_N + 1;
  localparam int unsigned S_SIN = DIV_N + $clog2(DIV_SIN);
  localparam int unsigned S_COS = DIV_N + $clog2(DIV_COS);
  localparam logic [63:0] M_SIN_W = ((64'd1 << S_SIN) + 64'(DIV_SIN) - 64'd1) / 64'(DIV_SIN);
  localparam logic [63:0] M_COS_W = ((64'd1 << S_COS) + 64'(DIV_COS) - 64'd1) / 64'(DIV_COS);
  localparam logic [DIV_N:0] M_SIN = M_SIN_W[DIV_N:0];
  localparam logic [DIV_N:0] M_COS = M_COS_W[DIV_N:0];
  localparam logic [DW-1:0] D_SIN = DW'(DIV_SIN);
  localparam logic [DW-1:0] D_COS = DW'(DIV_COS);

  logic [5:0]       v_q;
  tscu_sb_t         sb_q [6];
  logic [PPW-1:0]   pp_hi_q, pp_lo_q;
  logic [TW-1:0]    p_q;
  logic [PRW-1:0]   prod_a_q, prod_b_q;
  logic [DIV_N-1:0] n1_q;
  logic [HW-1:0]    plo2_q, plo3_q;
  logic [HW-1:0]    qa3_q, qa4_q;
  logic [RW-1:0]    ra_q;
  logic [TW-1:0]    t_q;

  logic [SUMW-1:0]  sum_pp;
  logic [DIV_N-1:0] n1, n2, qd;
  logic [DIV_N:0]   msel2, msel4;
  logic [PRW-1:0]   sh_a, sh_b;
  logic [HW-1:0]    qa, qb;
  logic [DW-1:0]    dsel3;

  always_comb begin
    sum_pp = {pp_hi_q, {HW{1'b0}}} + SUMW'(pp_lo_q);
    n1     = {{RW{1'b0}}, p_q[TW-1:HW]};
    msel2  = sb_q[1].cosine ? M_COS : M_SIN;
    // high chunk quotient and remainder
    sh_a   = sb_q[2].cosine ? (prod_a_q >> S_COS) : (prod_a_q >> S_SIN);
    qa     = sh_a[HW-1:0];
    dsel3  = sb_q[2].cosine ? D_COS : D_SIN;
    qd     = DIV_N'(qa) * DIV_N'(dsel3);
    n2     = {ra_q, plo3_q};
    msel4  = sb_q[3].cosine ? M_COS : M_SIN;
    sh_b   = sb_q[4].cosine ? (prod_b_q >> S_COS) : (prod_b_q >> S_SIN);
    qb     = sh_b[HW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0]  <= sb_i;
      for (int i = 1; i < 6; i++) begin
        sb_q[i] <= sb_q[i-1];
      end
      pp_hi_q  <= PPW'(t_i[TW-1:HW]) * PPW'(sb_i.ax);
      pp_lo_q  <= PPW'(t_i[HW-1:0]) * PPW'(sb_i.ax);
      p_q      <= sum_pp[FRAC +: TW];
      prod_a_q <= PRW'(n1) * PRW'(msel2);
      n1_q     <= n1;
      plo2_q   <= p_q[HW-1:0];
      qa3_q    <= qa;
      ra_q     <= RW'(n1_q - qd);
      plo3_q   <= plo2_q;
      prod_b_q <= PRW'(n2) * PRW'(msel4);
      qa4_q    <= qa3_q;
      t_q      <= {qa4_q, qb};
    end
  end

  assign valid_o = v_q[5];
  assign t_o     = t_q;
  assign sb_o    = sb_q[5];

endmodule
`default_nettype wire

@@ rtl/taylor_sine_cosine_unit_top.sv @@
// one beat accepted per cycle unless a result beat is stalled at the output register
// five degree-reduction stages, twelve stages per series term, two output stages
// the whole pipeline holds while a result beat is stalled at the output register
// reset clears the valid bits only; no clearing pass
`default_nettype none
module taylor_sine_cosine_unit_top #(
  parameter int unsigned NUM_TERMS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic signed [31:0] angle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [31:0] value_o
);
  import tscu_pkg::*;

  localparam logic [8:0] ANG_QUARTER = 9'd90;
  localparam logic [8:0] ANG_HALF    = 9'd180;
  localparam logic [8:0] ANG_THREE_Q = 9'd270;

  logic en;
  logic out_valid_q;
  logic [31:0] value_q;

  assign en          = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);

  // degree reduction stages
  logic        d0_v_q, d1_v_q, d2_v_q, d3_v_q, d4_v_q;
  logic [1:0]  d0_mode_q, d1_mode_q;
  logic        d0_neg_q, d1_neg_q, d2_neg_q, d3_neg_q;
  logic [31:0] d0_n_q, d1_n_q, d2_n_q, d3_n_q;
  logic [55:0] d0_prod_q;
  logic [8:0]  d1_m_q;
  logic        d2_cos_q, d3_cos_q, d2_deg_q, d3_deg_q;
  logic        d2_spec_q, d3_spec_q, d2_one_q, d3_one_q, d2_sneg_q, d3_sneg_q;
  logic [41:0] d2_x_q, d3_x_q;
  logic [31:0] d2_base_q, d3_base_q;
  logic [53:0] d3_prod_q;
  logic [TW-1:0] d4_t_q;
  tscu_sb_t    d4_sb_q;

  logic        in_neg;
  logic [31:0] in_mag;
  logic [23:0] q360;
  logic [31:0] r360_full;
  logic [9:0]  r360;
  logic [8:0]  m_red;
  logic        is0, is90, is180, is270, m_deg, m_cos;
  logic [9:0]  dq0, dq;
  logic [41:0] drem;
  logic [31:0] ax_deg, ax_sel;
  logic [TW-1:0] t0;

  always_comb begin
    in_neg    = angle_i[31];
    in_mag    = in_neg ? (~angle_i + 32'd1) : angle_i;
    q360      = d0_prod_q[55:32];
    r360_full = d0_n_q - 32'(q360) * 32'(DEG_TURN);
    r360      = r360_full[9:0];
    m_red     = (r360 >= 10'(DEG_TURN)) ? 9'(r360 - 10'(DEG_TURN)) : r360[8:0];
    m_deg     = d1_mode_q[MODE_DEG_BIT];
    m_cos     = d1_mode_q[MODE_COS_BIT];
    is0       = d1_m_q == 9'd0;
    is90      = d1_m_q == ANG_QUARTER;
    is180     = d1_m_q == ANG_HALF;
    is270     = d1_m_q == ANG_THREE_Q;
    // quotient estimate is low by at most one
    dq0       = d3_prod_q[53:44];
    drem      = d3_x_q - 42'(dq0) * 42'(DEG_D);
    dq        = (drem >= 42'(DEG_D)) ? dq0 + 10'd1 : dq0;
    ax_deg    = d3_base_q + 32'(dq);
    ax_sel    = d3_deg_q ? ax_deg : d3_n_q;
    t0        = d3_cos_q ? TW'(Q30_ONE) : {10'b0, ax_sel, 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_v_q <= 1'b0;
      d1_v_q <= 1'b0;
      d2_v_q <= 1'b0;
      d3_v_q <= 1'b0;
      d4_v_q <= 1'b0;
    end else if (en) begin
      d0_v_q <= in_valid_i;
      d1_v_q <= d0_v_q;
      d2_v_q <= d1_v_q;
      d3_v_q <= d2_v_q;
      d4_v_q <= d3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_mode_q <= mode_i;
      d0_neg_q  <= in_neg;
      d0_n_q    <= in_mag;
      d0_prod_q <= 56'(in_mag) * 56'(MINV360);

      d1_mode_q <= d0_mode_q;
      d1_neg_q  <= d0_neg_q;
      d1_n_q    <= d0_n_q;
      d1_m_q    <= m_red;

      d2_cos_q  <= m_cos;
      d2_deg_q  <= m_deg;
      d2_neg_q  <= d1_neg_q;
      d2_n_q    <= d1_n_q;
      d2_x_q    <= 42'(d1_m_q) * 42'(DEG_R) + 42'(DEG_H);
      d2_base_q <= 32'(d1_m_q) * 32'(DEG_Q);
      // exact cases; negative remainders only when zero
      d2_spec_q <= m_deg && (is0 || (!d1_neg_q && (is90 || is180 || is270)));
      d2_one_q  <= m_cos ? (is0 || is180) : (is90 || is270);
      d2_sneg_q <= m_cos ? is180 : is270;

      d3_cos_q  <= d2_cos_q;
      d3_deg_q  <= d2_deg_q;
      d3_neg_q  <= d2_neg_q;
      d3_n_q    <= d2_n_q;
      d3_x_q    <= d2_x_q;
      d3_base_q <= d2_base_q;
      d3_prod_q <= 54'(d2_x_q) * 54'(DEG_MINV);
      d3_spec_q <= d2_spec_q;
      d3_one_q  <= d2_one_q;
      d3_sneg_q <= d2_sneg_q;

      d4_t_q           <= t0;
      d4_sb_q.cosine   <= d3_cos_q;
      d4_sb_q.neg      <= d3_neg_q;
      d4_sb_q.spec     <= d3_spec_q;
      d4_sb_q.spec_one <= d3_one_q;
      d4_sb_q.spec_neg <= d3_sneg_q;
      d4_sb_q.ax       <= ax_sel;
      d4_sb_q.sum      <= $signed({{(SW-TW){1'b0}}, t0});
    end
  end

  // series terms
  logic          chain_v  [NUM_TERMS];
  logic [TW-1:0] chain_t  [NUM_TERMS-1];
  tscu_sb_t      chain_sb [NUM_TERMS];

  assign chain_v[0]  = d4_v_q;
  assign chain_t[0]  = d4_t_q;
  assign chain_sb[0] = d4_sb_q;

  for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
    logic          mid_v, end_v;
    logic [TW-1:0] mid_t, end_t;
    tscu_sb_t      mid_sb, end_sb;
    logic signed [SW-1:0] term;

    tscu_half_step #(
      .DIV_SIN (2 * k),
      .DIV_COS (2 * k - 1)
    ) u_half_a (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[k-1]),
      .t_i     (chain_t[k-1]),
      .sb_i    (chain_sb[k-1]),
      .valid_o (mid_v),
      .t_o     (mid_t),
      .sb_o    (mid_sb)
    );

    tscu_half_step #(
      .DIV_SIN (2 * k + 1),
      .DIV_COS (2 * k)
    ) u_half_b (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (mid_v),
      .t_i     (mid_t),
      .sb_i    (mid_sb),
      .valid_o (end_v),
      .t_o     (end_t),
      .sb_o    (end_sb)
    );

    assign term       = $signed({{(SW-TW){1'b0}}, end_t});
    assign chain_v[k] = end_v;

    // odd terms subtract
    if (k % 2 == 1) begin : g_sub
      always_comb begin
        chain_sb[k]     = end_sb;
        chain_sb[k].sum = end_sb.sum - term;
      end
    end else begin : g_add
      always_comb begin
        chain_sb[k]     = end_sb;
        chain_sb[k].sum = end_sb.sum + term;
      end
    end

    if (k < NUM_TERMS - 1) begin : g_fwd
      assign chain_t[k] = end_t;
    end
  end

  // final sum, sign, exact cases and saturation
  logic                 f_v_q;
  logic signed [SW-1:0] f_sum_q;
  logic                 f_negs_q, f_spec_q, f_one_q, f_sneg_q;
  logic signed [SW-1:0] fin;
  logic [31:0]          value_d;

  always_comb begin
    fin = f_negs_q ? -f_sum_q : f_sum_q;
    priority if (f_spec_q) begin
      value_d = f_one_q ? (f_sneg_q ? Q30_MIN_ONE : Q30_ONE) : 32'd0;
    end else if (fin > SAT_HI) begin
      value_d = SAT_HI[31:0];
    end else if (fin < SAT_LO) begin
      value_d = SAT_LO[31:0];
    end else begin
      value_d = fin[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      f_v_q       <= chain_v[NUM_TERMS-1];
      out_valid_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_sum_q  <= chain_sb[NUM_TERMS-1].sum;
      f_negs_q <= !chain_sb[NUM_TERMS-1].cosine && chain_sb[NUM_TERMS-1].neg;
      f_spec_q <= chain_sb[NUM_TERMS-1].spec;
      f_one_q  <= chain_sb[NUM_TERMS-1].spec_one;
      f_sneg_q <= chain_sb[NUM_TERMS-1].spec_neg;
      value_q  <= value_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tscu_checker.sv @@
// tscu_checker: port-level checks of the taylor sine/cosine unit, bound to the top level
// sees only the top-level ports; no package needed
`default_nettype none
module tscu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o))
    else $error("result value changed while stalled");

  // back-pressure reaches the input side
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output held");

  // an empty output register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind taylor_sine_cosine_unit_top tscu_checker u_tscu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o)
);
`default_nettype wire
